// ===== design/spqwc_pkg.sv =====
package spqwc_pkg;

  // queue geometry
  localparam int DEPTH       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  // field widths
  localparam int EXAM_W    = 16;
  localparam int PATIENT_W = 16;
  localparam int MACHINE_W = 8;
  localparam int PRIO_W    = 3;
  localparam int WAIT_W    = 16;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_INITIAL_WAIT = 1'b0;
  localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(30);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_APPEND = 2'd1,
    FN_REMOVE = 2'd2,
    FN_TICK   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [EXAM_W-1:0]    exam_id;
    logic [PATIENT_W-1:0] subject_id;
    logic [MACHINE_W-1:0] scanner_id;
    logic [PRIO_W-1:0]    prio;
    logic [WAIT_W-1:0]    wait_cnt;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // apply the operation and load the result register
  } cmd_t;

endpackage

// ===== design/spqwc_ctrl.sv =====
module spqwc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spqwc_pkg::cmd_t   cmd
);

  spqwc_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spqwc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    case (state_r)
      spqwc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = spqwc_pkg::ST_EXEC;
        end
      end
      spqwc_pkg::ST_EXEC: begin
        // wait until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spqwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spqwc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/spqwc_dp.sv =====
module spqwc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spqwc_pkg::cmd_t                     cmd,
  input  logic [spqwc_pkg::WAIT_W-1:0]        initial_wait,
  input  logic [spqwc_pkg::FUNC_W-1:0]        in_func,
  input  logic [spqwc_pkg::EXAM_W-1:0]        in_exam_id,
  input  logic [spqwc_pkg::PATIENT_W-1:0]     in_subject_id,
  input  logic [spqwc_pkg::MACHINE_W-1:0]     in_scanner_id,
  input  logic [spqwc_pkg::PRIO_W-1:0]        in_prio,
  output logic [spqwc_pkg::STATUS_W-1:0]      out_status,
  output logic [spqwc_pkg::EXAM_W-1:0]        out_exam_id,
  output logic [spqwc_pkg::PATIENT_W-1:0]     out_subject_id,
  output logic [spqwc_pkg::MACHINE_W-1:0]     out_scanner_id,
  output logic [spqwc_pkg::PRIO_W-1:0]        out_prio,
  output logic [spqwc_pkg::WAIT_W-1:0]        out_wait,
  output logic [spqwc_pkg::COUNT_OUT_W-1:0]   out_stored_count
);

  // captured operation
  spqwc_pkg::func_t                 op_func_r;
  logic [spqwc_pkg::EXAM_W-1:0]     op_exam_r;
  logic [spqwc_pkg::PATIENT_W-1:0]  op_patient_r;
  logic [spqwc_pkg::MACHINE_W-1:0]  op_machine_r;
  logic [spqwc_pkg::PRIO_W-1:0]     op_prio_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func_r    <= spqwc_pkg::func_t'(in_func);
      op_exam_r    <= in_exam_id;
      op_patient_r <= in_subject_id;
      op_machine_r <= in_scanner_id;
      op_prio_r    <= in_prio;
    end
  end

  // slot row and fill count
  spqwc_pkg::rec_t             slot_r [spqwc_pkg::DEPTH];
  logic [spqwc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                        full, empty;
  spqwc_pkg::rec_t             new_rec;

  assign full  = (count_r == spqwc_pkg::CNT_W'(spqwc_pkg::DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    new_rec.exam_id    = op_exam_r;
    new_rec.subject_id = op_patient_r;
    new_rec.scanner_id = op_machine_r;
    new_rec.prio       = op_prio_r;
    new_rec.wait_cnt   = initial_wait;
  end

  // per-cell compare; the prefix OR marks cells behind the insert point
  logic [spqwc_pkg::DEPTH-1:0] hit;
  logic [spqwc_pkg::DEPTH-1:0] behind;
  logic [spqwc_pkg::DEPTH-1:0] is_tail;

  for (genvar gi = 0; gi < spqwc_pkg::DEPTH; gi++) begin : g_cell
    spqwc_pkg::rec_t prev_rec, next_rec, cell_nxt;

    assign hit[gi]     = (spqwc_pkg::CNT_W'(gi) < count_r) &&
                         (slot_r[gi].prio < op_prio_r);
    assign is_tail[gi] = (spqwc_pkg::CNT_W'(gi) == count_r);

    if (gi == 0) begin : g_first
      assign behind[gi] = 1'b0;
      assign prev_rec   = slot_r[gi];
    end else begin : g_rest
      assign behind[gi] = behind[gi-1] | hit[gi-1];
      assign prev_rec   = slot_r[gi-1];
    end

    if (gi == spqwc_pkg::DEPTH - 1) begin : g_last
      assign next_rec = slot_r[gi];
    end else begin : g_mid
      assign next_rec = slot_r[gi+1];
    end

    // cell update
    always_comb begin
      cell_nxt = slot_r[gi];
      case (op_func_r)
        spqwc_pkg::FN_INSERT: begin
          if (!full) begin
            if (behind[gi]) begin
              cell_nxt = prev_rec;
            end else if (hit[gi] || is_tail[gi]) begin
              cell_nxt = new_rec;
            end
          end
        end
        spqwc_pkg::FN_APPEND: begin
          if (!full && is_tail[gi]) begin
            cell_nxt = new_rec;
          end
        end
        spqwc_pkg::FN_REMOVE: begin
          if (!empty) begin
            cell_nxt = next_rec;
          end
        end
        spqwc_pkg::FN_TICK: begin
          if (slot_r[gi].wait_cnt != '1) begin
            cell_nxt.wait_cnt = slot_r[gi].wait_cnt + 1'b1;
          end
        end
        default: begin
          cell_nxt = slot_r[gi];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        slot_r[gi] <= cell_nxt;
      end
    end
  end

  // fill count and result word
  logic [spqwc_pkg::STATUS_W-1:0] res_status_nxt;
  spqwc_pkg::rec_t                res_rec_nxt;

  always_comb begin
    count_nxt      = count_r;
    res_status_nxt = spqwc_pkg::STS_OK;
    res_rec_nxt    = '0;
    case (op_func_r)
      spqwc_pkg::FN_INSERT, spqwc_pkg::FN_APPEND: begin
        if (full) begin
          res_status_nxt = spqwc_pkg::STS_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      spqwc_pkg::FN_REMOVE: begin
        if (empty) begin
          res_status_nxt = spqwc_pkg::STS_EMPTY;
        end else begin
          res_rec_nxt = slot_r[0];
          count_nxt   = count_r - 1'b1;
        end
      end
      spqwc_pkg::FN_TICK: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  logic [spqwc_pkg::STATUS_W-1:0] res_status_r;
  spqwc_pkg::rec_t                res_rec_r;
  logic [spqwc_pkg::CNT_W-1:0]    res_count_r;
  logic [31:0]                    res_count_ext;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_rec_r    <= res_rec_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign res_count_ext    = 32'(res_count_r);
  assign out_status       = res_status_r;
  assign out_exam_id      = res_rec_r.exam_id;
  assign out_subject_id   = res_rec_r.subject_id;
  assign out_scanner_id   = res_rec_r.scanner_id;
  assign out_prio         = res_rec_r.prio;
  assign out_wait         = res_rec_r.wait_cnt;
  assign out_stored_count = res_count_ext[spqwc_pkg::COUNT_OUT_W-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spqwc_pkg::CNT_W'(spqwc_pkg::DEPTH))
    else $error("fill count above depth");

  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !full &&
    (op_func_r == spqwc_pkg::FN_INSERT || op_func_r == spqwc_pkg::FN_APPEND)
    |=> count_r == $past(count_r) + 1'b1)
    else $error("store did not grow the queue by one");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && empty && op_func_r == spqwc_pkg::FN_REMOVE
    |=> res_status_r == spqwc_pkg::STS_EMPTY && res_rec_r == '0 && count_r == '0)
    else $error("remove on empty queue gave a record");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && full &&
    (op_func_r == spqwc_pkg::FN_INSERT || op_func_r == spqwc_pkg::FN_APPEND)
    |=> res_status_r == spqwc_pkg::STS_FULL && $stable(count_r))
    else $error("store into full queue changed the queue");

endmodule

// ===== design/stable_priority_queue_with_wait_count.sv =====
// Stable priority queue of exam records with saturating wait counters.
// Input channel (in_valid/in_ready) carries one operation word: in_func
// selects insert by priority, append at tail, remove head or tick all wait
// counters; the record fields are used by the two store operations.
// Result channel (out_valid/out_ready) returns exactly one word per
// operation: status (ok, empty, full), the removed record or zeros, and the
// number of stored records after the operation.
// Each operation passes through the two controller states: idle captures
// the word, then execute, in which the row of slot cells compares, shifts or
// increments in parallel and loads the result register. A new word is
// accepted only once the previous one has executed. A stalled receiver holds
// the finished result in the output register; the next word is still
// accepted and waits in the capture stage until the result register frees up.
// Synchronous active-low reset empties the queue and sets initial_wait to
// 30. initial_wait is written through the register port at address 0; the
// user must write it only while the queue is idle, the block does not
// enforce this. New records start their wait counter at that value.
module stable_priority_queue_with_wait_count (
  input  logic                                clk,
  input  logic                                rst_n,
  // operation channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spqwc_pkg::FUNC_W-1:0]        in_func,
  input  logic [spqwc_pkg::EXAM_W-1:0]        in_exam_id,
  input  logic [spqwc_pkg::PATIENT_W-1:0]     in_subject_id,
  input  logic [spqwc_pkg::MACHINE_W-1:0]     in_scanner_id,
  input  logic [spqwc_pkg::PRIO_W-1:0]        in_prio,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spqwc_pkg::STATUS_W-1:0]      out_status,
  output logic [spqwc_pkg::EXAM_W-1:0]        out_exam_id,
  output logic [spqwc_pkg::PATIENT_W-1:0]     out_subject_id,
  output logic [spqwc_pkg::MACHINE_W-1:0]     out_scanner_id,
  output logic [spqwc_pkg::PRIO_W-1:0]        out_prio,
  output logic [spqwc_pkg::WAIT_W-1:0]        out_wait,
  output logic [spqwc_pkg::COUNT_OUT_W-1:0]   out_stored_count,
  // register port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [spqwc_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [spqwc_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [spqwc_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                                cfg_pready
);

  // configuration register
  logic [spqwc_pkg::WAIT_W-1:0] initial_wait_r;
  logic                         reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == spqwc_pkg::REG_INITIAL_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_wait_r <= spqwc_pkg::WAIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      initial_wait_r <= cfg_pwdata[spqwc_pkg::WAIT_W-1:0];
    end
  end

  assign cfg_prdata = reg_sel ? spqwc_pkg::DATA_W'(initial_wait_r) : '0;

  // controller and datapath
  spqwc_pkg::cmd_t cmd;

  spqwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spqwc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .initial_wait     (initial_wait_r),
    .in_func          (in_func),
    .in_exam_id       (in_exam_id),
    .in_subject_id    (in_subject_id),
    .in_scanner_id    (in_scanner_id),
    .in_prio          (in_prio),
    .out_status       (out_status),
    .out_exam_id      (out_exam_id),
    .out_subject_id   (out_subject_id),
    .out_scanner_id   (out_scanner_id),
    .out_prio         (out_prio),
    .out_wait         (out_wait),
    .out_stored_count (out_stored_count)
  );

endmodule

// ===== tb/stable_priority_queue_with_wait_count_tb.sv =====
module stable_priority_queue_with_wait_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one result word as it appears on the out_ channel
  typedef struct packed {
    spqwc_pkg::status_t                status;
    logic [spqwc_pkg::EXAM_W-1:0]      exam_id;
    logic [spqwc_pkg::PATIENT_W-1:0]   subject_id;
    logic [spqwc_pkg::MACHINE_W-1:0]   scanner_id;
    logic [spqwc_pkg::PRIO_W-1:0]      prio;
    logic [spqwc_pkg::WAIT_W-1:0]      wait_cnt;
    logic [spqwc_pkg::COUNT_OUT_W-1:0] stored_count;
  } reply_t;

  // operation mixes for the random phases
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_TICK} op_mix_t;

  // Mirror of the record queue: tracks contents, predicts each reply word
  // and checks the replies in order.
  class exam_queue_mirror;
    spqwc_pkg::rec_t              slots[spqwc_pkg::DEPTH];
    int                           count = 0;
    logic [spqwc_pkg::WAIT_W-1:0] start_wait = spqwc_pkg::WAIT_RESET;
    reply_t                       pending_replies[$];
    int                           errors = 0;

    function void set_start_wait(logic [spqwc_pkg::WAIT_W-1:0] v);
      start_wait = v;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // apply one accepted operation word and queue its expected reply
    function void note_op(spqwc_pkg::func_t op, logic [spqwc_pkg::EXAM_W-1:0] exam,
                          logic [spqwc_pkg::PATIENT_W-1:0] patient,
                          logic [spqwc_pkg::MACHINE_W-1:0] mach,
                          logic [spqwc_pkg::PRIO_W-1:0] prio);
      reply_t r;
      int     pos;
      r = '0;
      r.status = spqwc_pkg::STS_OK;
      case (op)
        spqwc_pkg::FN_INSERT, spqwc_pkg::FN_APPEND: begin
          if (count >= spqwc_pkg::DEPTH) begin
            r.status = spqwc_pkg::STS_FULL;
          end else begin
            pos = count;
            // stable insert: stop at first entry of strictly lower priority
            if (op == spqwc_pkg::FN_INSERT) begin
              for (int i = 0; i < count; i++) begin
                if (slots[i].prio < prio) begin
                  pos = i;
                  break;
                end
              end
            end
            for (int i = count; i > pos; i--) slots[i] = slots[i-1];
            slots[pos].exam_id    = exam;
            slots[pos].subject_id = patient;
            slots[pos].scanner_id = mach;
            slots[pos].prio       = prio;
            slots[pos].wait_cnt   = start_wait;
            count++;
          end
        end
        spqwc_pkg::FN_REMOVE: begin
          if (count == 0) begin
            r.status = spqwc_pkg::STS_EMPTY;
          end else begin
            r.exam_id    = slots[0].exam_id;
            r.subject_id = slots[0].subject_id;
            r.scanner_id = slots[0].scanner_id;
            r.prio       = slots[0].prio;
            r.wait_cnt   = slots[0].wait_cnt;
            for (int i = 1; i < count; i++) slots[i-1] = slots[i];
            count--;
          end
        end
        default: begin
          // tick: saturating increment of every stored counter
          for (int i = 0; i < count; i++) begin
            if (slots[i].wait_cnt != '1) slots[i].wait_cnt++;
          end
        end
      endcase
      r.stored_count = spqwc_pkg::COUNT_OUT_W'(count);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("reply word with nothing pending: status %0d", got.status);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("exam_id", exp_r.exam_id, got.exam_id);
      compare_field("subject_id", exp_r.subject_id, got.subject_id);
      compare_field("scanner_id", exp_r.scanner_id, got.scanner_id);
      compare_field("prio", exp_r.prio, got.prio);
      compare_field("wait", exp_r.wait_cnt, got.wait_cnt);
      compare_field("stored_count", exp_r.stored_count, got.stored_count);
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [spqwc_pkg::FUNC_W-1:0]        in_func = '0;
  logic [spqwc_pkg::EXAM_W-1:0]        in_exam_id = '0;
  logic [spqwc_pkg::PATIENT_W-1:0]     in_subject_id = '0;
  logic [spqwc_pkg::MACHINE_W-1:0]     in_scanner_id = '0;
  logic [spqwc_pkg::PRIO_W-1:0]        in_prio = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [spqwc_pkg::STATUS_W-1:0]      out_status;
  logic [spqwc_pkg::EXAM_W-1:0]        out_exam_id;
  logic [spqwc_pkg::PATIENT_W-1:0]     out_subject_id;
  logic [spqwc_pkg::MACHINE_W-1:0]     out_scanner_id;
  logic [spqwc_pkg::PRIO_W-1:0]        out_prio;
  logic [spqwc_pkg::WAIT_W-1:0]        out_wait;
  logic [spqwc_pkg::COUNT_OUT_W-1:0]   out_stored_count;
  logic                                cfg_psel = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite = 1'b0;
  logic [spqwc_pkg::ADDR_W-1:0]        cfg_paddr = '0;
  logic [spqwc_pkg::DATA_W-1:0]        cfg_pwdata = '0;
  logic [spqwc_pkg::DATA_W-1:0]        cfg_prdata;
  logic                                cfg_pready;

  exam_queue_mirror mirror = new;
  int burst_left = 1;
  int rx_seg_left = 0;
  int rx_mode = 0;

  stable_priority_queue_with_wait_count dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_exam_id, .in_subject_id,
    .in_scanner_id, .in_prio,
    .out_valid, .out_ready, .out_status, .out_exam_id, .out_subject_id,
    .out_scanner_id, .out_prio, .out_wait, .out_stored_count,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: segments of always-ready, random stalls, or one ready in eight
  always @(posedge clk) begin
    if (rx_seg_left == 0) begin
      rx_seg_left <= $urandom_range(8, 64);
      rx_mode <= $urandom_range(0, 2);
    end else begin
      rx_seg_left <= rx_seg_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_seg_left % 8 == 0);
    endcase
  end

  // monitor: both handshakes sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        mirror.note_op(spqwc_pkg::func_t'(in_func), in_exam_id, in_subject_id,
                       in_scanner_id, in_prio);
      if (out_valid && out_ready)
        mirror.check_reply('{spqwc_pkg::status_t'(out_status), out_exam_id,
                             out_subject_id, out_scanner_id, out_prio, out_wait,
                             out_stored_count});
    end
  end

  // present one word and hold it until taken; gaps come between bursts
  task automatic send_op(spqwc_pkg::func_t op, logic [spqwc_pkg::EXAM_W-1:0] exam,
                         logic [spqwc_pkg::PATIENT_W-1:0] patient,
                         logic [spqwc_pkg::MACHINE_W-1:0] mach,
                         logic [spqwc_pkg::PRIO_W-1:0] prio);
    int gap;
    in_valid      <= 1'b1;
    in_func       <= op;
    in_exam_id    <= exam;
    in_subject_id <= patient;
    in_scanner_id <= mach;
    in_prio       <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_random(op_mix_t mix);
    int               roll;
    int               lim_ins;
    int               lim_app;
    int               lim_rem;
    spqwc_pkg::func_t op;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        lim_ins = 45; lim_app = 75; lim_rem = 90;
      end
      MIX_DRAIN: begin
        lim_ins = 20; lim_app = 30; lim_rem = 85;
      end
      MIX_EVEN: begin
        lim_ins = 30; lim_app = 55; lim_rem = 85;
      end
      default: begin
        lim_ins = 25; lim_app = 40; lim_rem = 60;
      end
    endcase
    if (roll < lim_ins) op = spqwc_pkg::FN_INSERT;
    else if (roll < lim_app) op = spqwc_pkg::FN_APPEND;
    else if (roll < lim_rem) op = spqwc_pkg::FN_REMOVE;
    else op = spqwc_pkg::FN_TICK;
    send_op(op, spqwc_pkg::EXAM_W'($urandom), spqwc_pkg::PATIENT_W'($urandom),
            spqwc_pkg::MACHINE_W'($urandom), spqwc_pkg::PRIO_W'($urandom_range(0, 7)));
  endtask

  // stop sending and let every pending reply word come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, then read back in the next transfer
  task automatic write_start_wait(logic [spqwc_pkg::WAIT_W-1:0] v);
    logic [spqwc_pkg::DATA_W-1:0] wdata;
    wdata = {16'($urandom), v};
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= spqwc_pkg::ADDR_W'(4 * spqwc_pkg::REG_INITIAL_WAIT);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mirror.set_start_wait(v);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mirror.compare_field("initial_wait readback", spqwc_pkg::DATA_W'(v), cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [spqwc_pkg::WAIT_W-1:0] wval;
    op_mix_t                      mix;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, reset wait value, priority order and FIFO among equals
    send_op(spqwc_pkg::FN_REMOVE, '0, '0, '0, '0);
    send_op(spqwc_pkg::FN_TICK, '0, '0, '0, '0);
    send_op(spqwc_pkg::FN_INSERT, '0, '0, '0, 3'd0);
    send_op(spqwc_pkg::FN_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7);
    send_op(spqwc_pkg::FN_INSERT, 16'h1234, 16'h5678, 8'h9A, 3'd7);
    send_op(spqwc_pkg::FN_APPEND, 16'hAAAA, 16'h5555, 8'hA5, 3'd3);
    send_op(spqwc_pkg::FN_TICK, '0, '0, '0, '0);
    repeat (5) send_op(spqwc_pkg::FN_REMOVE, '0, '0, '0, '0);
    wait_drained();

    // counter saturation at its maximum
    write_start_wait(16'hFFFE);
    send_op(spqwc_pkg::FN_INSERT, 16'h0F0F, 16'hF0F0, 8'h3C, 3'd5);
    repeat (3) send_op(spqwc_pkg::FN_TICK, '0, '0, '0, '0);
    send_op(spqwc_pkg::FN_REMOVE, '0, '0, '0, '0);
    wait_drained();

    // random phases, each with its own start value and operation mix
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: wval = '0;
        1: wval = 16'hFFFF;
        2: wval = 16'hFFFD;
        3: wval = 16'd1;
        default: wval = spqwc_pkg::WAIT_W'($urandom);
      endcase
      mix = op_mix_t'(p % 4);
      write_start_wait(wval);
      repeat (125) send_random(mix);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mirror.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
